// ===== rtl/core/hcbf_pkg.sv =====
package hcbf_pkg;

    localparam int FRAME_SIDE = 400;
    localparam int ADDR_W     = $clog2(FRAME_SIDE);
    localparam int BUMP_LO    = FRAME_SIDE / 3;
    localparam int BUMP_HI    = 2 * FRAME_SIDE / 3;

    localparam int ROW_W      = 9;
    localparam int COL_W      = 9;
    localparam int CH_W       = 8;
    localparam int HUE_W      = 8;
    localparam int LIM_W      = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    typedef struct packed {
        logic [HUE_W-1:0] hue_low;
        logic [HUE_W-1:0] hue_high;
        logic [CH_W-1:0]  sat_min;
        logic [CH_W-1:0]  val_min;
        logic [LIM_W-1:0] sky_last_row;
        logic [LIM_W-1:0] wheel_first_row;
        logic [LIM_W-1:0] bumper_first_row;
    } t_cfg;

endpackage

// ===== rtl/core/hcbf_ram.sv =====
module hcbf_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 400
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/hcbf_color.sv =====
module hcbf_color (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  hcbf_pkg::t_cfg            i_cfg,
    input  logic [hcbf_pkg::CH_W-1:0] i_blue,
    input  logic [hcbf_pkg::CH_W-1:0] i_green,
    input  logic [hcbf_pkg::CH_W-1:0] i_red,
    output logic                      o_ok
);

    import hcbf_pkg::*;

    localparam int HP_W  = 11;
    localparam int X_W   = 17;
    localparam int Y_W   = CH_W + 1;
    localparam int SP_W  = 2 * CH_W;
    localparam int SL_W  = 17;
    localparam int A_W   = 9;
    localparam int BL_W  = 7;
    localparam int BH_W  = 5;
    localparam int PA_W  = A_W + Y_W;
    localparam int PBL_W = BL_W + Y_W;
    localparam int PBH_W = BH_W + Y_W;

    // quotient q = h + 30 (mod 180 wrap): hue 0 sits at q = 30
    localparam logic [A_W-1:0]   Q_OFS      = A_W'(30);
    localparam logic [HUE_W-1:0] HUE_B_LO   = HUE_W'(150);
    localparam logic [HUE_W-1:0] HUE_TOP    = HUE_W'(179);
    localparam logic [BH_W-1:0]  B_SPAN     = BH_W'(30);

    // hue window bounds, as quotient ranges
    logic [A_W-1:0]  r_a_lo;
    logic [A_W-1:0]  r_a_hi1;
    logic            r_b_en;
    logic [BL_W-1:0] r_b_lo;
    logic [BH_W-1:0] r_b_hi1;

    always_ff @(posedge i_clk) begin
        r_a_lo  <= A_W'(i_cfg.hue_low) + Q_OFS;
        r_a_hi1 <= A_W'(i_cfg.hue_high) + Q_OFS + A_W'(1);
        r_b_en  <= i_cfg.hue_high >= HUE_B_LO;
        r_b_lo  <= (i_cfg.hue_low > HUE_B_LO) ? BL_W'(i_cfg.hue_low - HUE_B_LO) : '0;
        r_b_hi1 <= (i_cfg.hue_high >= HUE_TOP) ? B_SPAN
                                               : BH_W'(i_cfg.hue_high - HUE_B_LO + HUE_W'(1));
    end

    // stage 1: max, min, chroma, offset hue numerator
    logic [CH_W-1:0] c_max, c_min, c_d;
    logic [HP_W-1:0] c_hp;

    always_comb begin
        c_max = i_red;
        if (i_green > c_max) c_max = i_green;
        if (i_blue > c_max) c_max = i_blue;
        c_min = i_red;
        if (i_green < c_min) c_min = i_green;
        if (i_blue < c_min) c_min = i_blue;
        c_d = c_max - c_min;
        priority if (c_max == i_red) begin
            c_hp = HP_W'(i_green) + HP_W'(c_d) - HP_W'(i_blue);
        end else if (c_max == i_green) begin
            c_hp = HP_W'(i_blue) + (HP_W'(c_d) << 1) + HP_W'(c_d) - HP_W'(i_red);
        end else begin
            c_hp = HP_W'(i_red) + (HP_W'(c_d) << 2) + HP_W'(c_d) - HP_W'(i_green);
        end
    end

    logic [CH_W-1:0] r2_v, r2_d;
    logic [HP_W-1:0] r2_hp;
    logic            r2_val_ok;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_v      <= c_max;
            r2_d      <= c_d;
            r2_hp     <= c_hp;
            r2_val_ok <= c_max >= i_cfg.val_min;
        end
    end

    // stage 2: hue dividend 60*hp + d, divisor 2d, saturation terms
    logic [X_W-1:0]  c_x;
    logic [Y_W-1:0]  c_y;
    logic [SP_W-1:0] c_sprod;
    logic [SL_W-1:0] c_slhs;

    always_comb begin
        c_x     = (X_W'(r2_hp) << 6) - (X_W'(r2_hp) << 2) + X_W'(r2_d);
        c_y     = {r2_d, 1'b0};
        c_sprod = SP_W'(r2_v) * SP_W'(i_cfg.sat_min);
        c_slhs  = (SL_W'(r2_d) << 9) - (SL_W'(r2_d) << 1) + SL_W'(r2_v);
    end

    logic [X_W-1:0]  r3_x;
    logic [Y_W-1:0]  r3_y;
    logic [SP_W-1:0] r3_sprod;
    logic [SL_W-1:0] r3_slhs;
    logic            r3_vz, r3_dz, r3_val_ok;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_x      <= c_x;
            r3_y      <= c_y;
            r3_sprod  <= c_sprod;
            r3_slhs   <= c_slhs;
            r3_vz     <= r2_v == '0;
            r3_dz     <= r2_d == '0;
            r3_val_ok <= r2_val_ok;
        end
    end

    // stage 3: bound products, saturation compare
    logic [PA_W-1:0]  c_pa_lo, c_pa_hi;
    logic [PBL_W-1:0] c_pb_lo;
    logic [PBH_W-1:0] c_pb_hi;
    logic             c_sat_ok;

    always_comb begin
        c_pa_lo  = PA_W'(r_a_lo) * PA_W'(r3_y);
        c_pa_hi  = PA_W'(r_a_hi1) * PA_W'(r3_y);
        c_pb_lo  = PBL_W'(r_b_lo) * PBL_W'(r3_y);
        c_pb_hi  = PBH_W'(r_b_hi1) * PBH_W'(r3_y);
        c_sat_ok = r3_vz ? (i_cfg.sat_min == '0) : (r3_slhs >= {r3_sprod, 1'b0});
    end

    logic [X_W-1:0]   r4_x;
    logic [PA_W-1:0]  r4_pa_lo, r4_pa_hi;
    logic [PBL_W-1:0] r4_pb_lo;
    logic [PBH_W-1:0] r4_pb_hi;
    logic             r4_b_en, r4_dz, r4_sat_ok, r4_val_ok;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_x      <= r3_x;
            r4_pa_lo  <= c_pa_lo;
            r4_pa_hi  <= c_pa_hi;
            r4_pb_lo  <= c_pb_lo;
            r4_pb_hi  <= c_pb_hi;
            r4_b_en   <= r_b_en;
            r4_dz     <= r3_dz;
            r4_sat_ok <= c_sat_ok;
            r4_val_ok <= r3_val_ok;
        end
    end

    // stage 4: floor(x/y) in [lo, hi] <=> lo*y <= x < (hi+1)*y
    logic c_a_ok, c_b_ok, c_hue_ok;

    always_comb begin
        c_a_ok   = (PA_W'(r4_x) >= r4_pa_lo) && (PA_W'(r4_x) < r4_pa_hi);
        c_b_ok   = r4_b_en && (X_W'(r4_pb_lo) <= r4_x) && (r4_x < X_W'(r4_pb_hi));
        c_hue_ok = r4_dz ? (i_cfg.hue_low == '0) : (c_a_ok || c_b_ok);
        o_ok     = c_hue_ok && r4_sat_ok && r4_val_ok;
    end

endmodule

// ===== rtl/core/hsv_color_column_bottom_finder_top.sv =====
// BGR pixels of a FRAME_SIDE-square frame stream in, one transfer per clock while the
// output buffer is not full, with no gaps needed between them; every item (pixel or
// column query) gives one result, in order. The HSV window test runs through four
// register stages, and the column store (one RAM, one write and one read port) is read
// as an item enters and written as it leaves stage four, with in-flight writes
// forwarded, so back-to-back pixels of one column are handled at full rate. A two-entry
// output buffer lets the input keep flowing while one result waits. There is no
// clearing pass: a column's entry is set up by its row-0 pixel, and querying a column
// whose row-0 pixel has never been seen since reset returns an undefined answer.
module hsv_color_column_bottom_finder_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_cmd,
    input  logic [hcbf_pkg::ROW_W-1:0]      i_pix_row,
    input  logic [hcbf_pkg::COL_W-1:0]      i_pix_col,
    input  logic [hcbf_pkg::CH_W-1:0]       i_blue,
    input  logic [hcbf_pkg::CH_W-1:0]       i_green,
    input  logic [hcbf_pkg::CH_W-1:0]       i_red,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_is_match,
    output logic                            o_has_bottom,
    output logic [hcbf_pkg::ROW_W-1:0]      o_bottom_row,
    input  logic                            i_cfg_we,
    input  logic [hcbf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [hcbf_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    import hcbf_pkg::*;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_HUE_LOW     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_HUE_HIGH    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_SAT_MIN     = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_VAL_MIN     = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_SKY_LAST    = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_FIRST = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] CFG_BUMP_FIRST  = CFG_IDX_W'(6);

    typedef struct packed {
        logic             valid;
        logic [ROW_W-1:0] row;
    } t_entry;

    typedef struct packed {
        logic             is_match;
        logic             has_bottom;
        logic [ROW_W-1:0] bottom_row;
    } t_result;

    localparam int ENTRY_W = $bits(t_entry);

    // configuration
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hue_low          <= HUE_W'(5);
            r_cfg.hue_high         <= HUE_W'(15);
            r_cfg.sat_min          <= CH_W'(140);
            r_cfg.val_min          <= CH_W'(140);
            r_cfg.sky_last_row     <= LIM_W'(220);
            r_cfg.wheel_first_row  <= LIM_W'(200);
            r_cfg.bumper_first_row <= LIM_W'(200);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_HUE_LOW:     r_cfg.hue_low          <= i_cfg_wdata[HUE_W-1:0];
                CFG_HUE_HIGH:    r_cfg.hue_high         <= i_cfg_wdata[HUE_W-1:0];
                CFG_SAT_MIN:     r_cfg.sat_min          <= i_cfg_wdata[CH_W-1:0];
                CFG_VAL_MIN:     r_cfg.val_min          <= i_cfg_wdata[CH_W-1:0];
                CFG_SKY_LAST:    r_cfg.sky_last_row     <= i_cfg_wdata[LIM_W-1:0];
                CFG_WHEEL_FIRST: r_cfg.wheel_first_row  <= i_cfg_wdata[LIM_W-1:0];
                CFG_BUMP_FIRST:  r_cfg.bumper_first_row <= i_cfg_wdata[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline advance: stalls only when the output buffer is full
    logic [1:0] r_cnt;
    logic       c_en, c_fire;

    assign c_en       = r_cnt != 2'd2;
    assign c_fire     = i_in_valid && c_en;
    assign o_in_ready = c_en;

    logic r_v1, r_v2, r_v3, r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (c_en) begin
            r_v1 <= c_fire;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // store write from stage 4, forwarded to younger items of the same column
    logic         c_wr;
    t_entry       c_wdata;
    logic [ENTRY_W-1:0] c_rdata;
    logic [ADDR_W-1:0]  c_raddr;

    logic             r1_cmd, r1_fwd;
    logic [ROW_W-1:0] r1_row;
    logic [COL_W-1:0] r1_col;
    logic [CH_W-1:0]  r1_blue, r1_green, r1_red;
    t_entry           r1_fwd_ent;

    logic             r2_cmd, r2_row_in, r2_col_in, r2_mask;
    logic [ROW_W-1:0] r2_row;
    logic [COL_W-1:0] r2_col;
    t_entry           r2_ent;

    logic             r3_cmd, r3_row_in, r3_col_in, r3_mask;
    logic [ROW_W-1:0] r3_row;
    logic [COL_W-1:0] r3_col;
    t_entry           r3_ent;

    logic             r4_cmd, r4_row_in, r4_col_in, r4_mask;
    logic [ROW_W-1:0] r4_row;
    logic [COL_W-1:0] r4_col;
    t_entry           r4_ent;

    logic c_hit_in, c_hit1, c_hit2, c_hit3;

    assign c_hit_in = c_wr && (i_pix_col == r4_col);
    assign c_hit1   = c_wr && (r1_col == r4_col);
    assign c_hit2   = c_wr && (r2_col == r4_col);
    assign c_hit3   = c_wr && (r3_col == r4_col);

    assign c_raddr = (int'(i_pix_col) < FRAME_SIDE) ? ADDR_W'(i_pix_col) : '0;

    hcbf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (FRAME_SIDE)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (c_wr),
        .i_waddr (ADDR_W'(r4_col)),
        .i_wdata (c_wdata),
        .i_re    (c_en),
        .i_raddr (c_raddr),
        .o_rdata (c_rdata)
    );

    // stage 1
    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r1_cmd     <= i_cmd;
            r1_row     <= i_pix_row;
            r1_col     <= i_pix_col;
            r1_blue    <= i_blue;
            r1_green   <= i_green;
            r1_red     <= i_red;
            r1_fwd     <= c_hit_in;
            r1_fwd_ent <= c_wdata;
        end
    end

    logic   c1_row_in, c1_col_in, c1_mask;
    t_entry c1_ent;

    always_comb begin
        c1_row_in = int'(r1_row) < FRAME_SIDE;
        c1_col_in = int'(r1_col) < FRAME_SIDE;
        c1_mask   = (LIM_W'(r1_row) <= r_cfg.sky_last_row)
                 || (LIM_W'(r1_row) >= r_cfg.wheel_first_row)
                 || ((int'(r1_col) >= BUMP_LO) && (int'(r1_col) <= BUMP_HI)
                     && (LIM_W'(r1_row) >= r_cfg.bumper_first_row));
        c1_ent    = r1_fwd ? r1_fwd_ent : t_entry'(c_rdata);
    end

    // stages 2 to 4 carry the store entry
    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r2_cmd    <= r1_cmd;
            r2_row    <= r1_row;
            r2_col    <= r1_col;
            r2_row_in <= c1_row_in;
            r2_col_in <= c1_col_in;
            r2_mask   <= c1_mask;
            r2_ent    <= c_hit1 ? c_wdata : c1_ent;

            r3_cmd    <= r2_cmd;
            r3_row    <= r2_row;
            r3_col    <= r2_col;
            r3_row_in <= r2_row_in;
            r3_col_in <= r2_col_in;
            r3_mask   <= r2_mask;
            r3_ent    <= c_hit2 ? c_wdata : r2_ent;

            r4_cmd    <= r3_cmd;
            r4_row    <= r3_row;
            r4_col    <= r3_col;
            r4_row_in <= r3_row_in;
            r4_col_in <= r3_col_in;
            r4_mask   <= r3_mask;
            r4_ent    <= c_hit3 ? c_wdata : r3_ent;
        end
    end

    logic c4_color_ok;

    hcbf_color u_color (
        .i_clk   (i_clk),
        .i_en    (c_en),
        .i_cfg   (r_cfg),
        .i_blue  (r1_blue),
        .i_green (r1_green),
        .i_red   (r1_red),
        .o_ok    (c4_color_ok)
    );

    // stage 4: match, store update, result
    logic    c4_pix, c4_match;
    t_result c_res;

    always_comb begin
        c4_pix   = (r4_cmd == CMD_PIXEL) && r4_row_in && r4_col_in;
        c4_match = c4_pix && !r4_mask && c4_color_ok;

        c_wr    = 1'b0;
        c_wdata = '0;
        if (r_v4 && c_en && c4_pix) begin
            // row 0 starts the column afresh
            priority if (r4_row == '0) begin
                c_wr          = 1'b1;
                c_wdata.valid = c4_match;
            end else if (c4_match && (!r4_ent.valid || r4_row >= r4_ent.row)) begin
                c_wr          = 1'b1;
                c_wdata.valid = 1'b1;
                c_wdata.row   = r4_row;
            end else begin
                c_wr          = 1'b0;
            end
        end

        c_res.is_match   = c4_match;
        c_res.has_bottom = (r4_cmd == CMD_QUERY) && r4_col_in && r4_ent.valid;
        c_res.bottom_row = c_res.has_bottom ? r4_ent.row : '0;
    end

    // two-entry output buffer
    t_result r_head, r_tail;
    logic    c_push, c_pop;

    assign c_push = c_en && r_v4;
    assign c_pop  = (r_cnt != 2'd0) && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            unique case ({c_push, c_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_cnt)
            2'd0: begin
                if (c_push) r_head <= c_res;
            end
            2'd1: begin
                if (c_push && c_pop) begin
                    r_head <= c_res;
                end else if (c_push) begin
                    r_tail <= c_res;
                end
            end
            default: begin
                if (c_pop) r_head <= r_tail;
            end
        endcase
    end

    assign o_out_valid  = r_cnt != 2'd0;
    assign o_is_match   = r_head.is_match;
    assign o_has_bottom = r_head.has_bottom;
    assign o_bottom_row = r_head.bottom_row;

endmodule
